// File: sv/assert_macros.svh
// Assertion macros used by the checker module.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/sdhrs_pkg.sv
// Register map, status bits and reset values of the SD host register stub.
// Self-contained; imported by the top level.
`timescale 1ns / 1ps

package sdhrs_pkg;

  localparam int OfsW = 6;
  localparam int DataW = 32;

  typedef logic [OfsW-1:0] ofs_t;
  typedef logic [DataW-1:0] word_t;

  // Access kinds.
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Byte offsets within the window.
  localparam ofs_t OFS_CLK_CTRL  = 6'h00;
  localparam ofs_t OFS_STATUS    = 6'h04;
  localparam ofs_t OFS_CLK_RATE  = 6'h08;
  localparam ofs_t OFS_CMD_CTRL  = 6'h0C;
  localparam ofs_t OFS_RES_TO    = 6'h10;
  localparam ofs_t OFS_READ_TO   = 6'h14;
  localparam ofs_t OFS_BLK_LEN   = 6'h18;
  localparam ofs_t OFS_BLK_CNT   = 6'h1C;
  localparam ofs_t OFS_REVISION  = 6'h20;
  localparam ofs_t OFS_INT_EN    = 6'h24;
  localparam ofs_t OFS_CMD_IDX   = 6'h28;
  localparam ofs_t OFS_CMD_ARG   = 6'h2C;
  localparam ofs_t OFS_RESP_FIFO = 6'h34;
  localparam ofs_t OFS_DATA_FIFO = 6'h38;

  // Bit positions.
  localparam int CLK_START_BIT   = 1;
  localparam int CLK_STOP_BIT    = 0;
  localparam int ST_RESP_TIMEOUT = 1;
  localparam int ST_CLK_RUNNING  = 8;
  localparam int ST_END_CMD      = 13;
  localparam int IE_END_CMD      = 2;

  // Fixed words and reset values.
  localparam word_t REVISION_WORD    = 32'h0000_0400;
  localparam word_t STATUS_AT_RESET  = 32'h3000_0000;
  localparam word_t CLK_RATE_RESET   = 32'h0000_0008;
  localparam word_t RES_TO_RESET     = 32'h0000_0040;
  localparam word_t READ_TO_RESET    = 32'h0000_FFFF;

endpackage

// File: sv/sd_host_register_stub_top.sv
// Top level of the SD host register stub: register file, decode and result register.
// Depends on sdhrs_pkg.
`timescale 1ns / 1ps

// Register file of an SD host controller with no card attached. Each input
// transaction is one read or write at a byte offset in a 64-byte window, and
// produces exactly one result transaction in the cycle after it is accepted. The
// decode is combinational and registered on acceptance, so one transaction per cycle
// is sustained; the only limit is the single result register, and in_ready is
// high whenever that register is empty or being taken in the same cycle.
// Unmapped offsets and writes to read-only offsets return bad_access with
// zero data and leave every register untouched. irq is the interrupt level
// after the access: end-of-command status together with its enable.
module sd_host_register_stub_top
  import sdhrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [OfsW-1:0]   offset,
  input  logic [DataW-1:0]  write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DataW-1:0]  read_data,
  output logic              irq,
  output logic              bad_access
);

  word_t clock_control, clock_control_next;
  word_t status_word, status_word_next;
  word_t clock_rate, clock_rate_next;
  word_t command_control, command_control_next;
  word_t response_timeout, response_timeout_next;
  word_t read_timeout, read_timeout_next;
  word_t block_length, block_length_next;
  word_t block_count, block_count_next;
  word_t interrupt_enables, interrupt_enables_next;
  word_t command_index, command_index_next;
  word_t command_argument, command_argument_next;

  word_t rd_value;
  logic  ok;
  logic  accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    clock_control_next     = clock_control;
    status_word_next       = status_word;
    clock_rate_next        = clock_rate;
    command_control_next   = command_control;
    response_timeout_next  = response_timeout;
    read_timeout_next      = read_timeout;
    block_length_next      = block_length;
    block_count_next       = block_count;
    interrupt_enables_next = interrupt_enables;
    command_index_next     = command_index;
    command_argument_next  = command_argument;
    rd_value = '0;
    ok       = 1'b1;

    if (func == FUNC_WRITE) begin
      unique case (offset)
        OFS_CLK_CTRL: begin
          clock_control_next = write_data;
          // Stop wins when start and stop are written together.
          if (write_data[CLK_START_BIT]) status_word_next[ST_CLK_RUNNING] = 1'b1;
          if (write_data[CLK_STOP_BIT]) status_word_next[ST_CLK_RUNNING] = 1'b0;
        end
        OFS_STATUS:   status_word_next = status_word & ~write_data;
        OFS_CLK_RATE: clock_rate_next = write_data;
        OFS_CMD_CTRL: begin
          command_control_next = write_data;
          // No card ever answers, so a command ends at once with a timeout.
          status_word_next[ST_END_CMD]      = 1'b1;
          status_word_next[ST_RESP_TIMEOUT] = 1'b1;
        end
        OFS_RES_TO:    response_timeout_next = write_data;
        OFS_READ_TO:   read_timeout_next = write_data;
        OFS_BLK_LEN:   block_length_next = write_data;
        OFS_BLK_CNT:   block_count_next = write_data;
        OFS_INT_EN:    interrupt_enables_next = write_data;
        OFS_CMD_IDX:   command_index_next = write_data;
        OFS_CMD_ARG:   command_argument_next = write_data;
        OFS_DATA_FIFO: ok = 1'b1;
        default:       ok = 1'b0;
      endcase
    end else begin
      unique case (offset)
        OFS_CLK_CTRL:  rd_value = clock_control;
        OFS_STATUS:    rd_value = status_word;
        OFS_CLK_RATE:  rd_value = clock_rate;
        OFS_CMD_CTRL:  rd_value = command_control;
        OFS_RES_TO:    rd_value = response_timeout;
        OFS_READ_TO:   rd_value = read_timeout;
        OFS_BLK_LEN:   rd_value = block_length;
        OFS_BLK_CNT:   rd_value = block_count;
        OFS_REVISION:  rd_value = REVISION_WORD;
        OFS_INT_EN:    rd_value = interrupt_enables;
        OFS_CMD_IDX:   rd_value = command_index;
        OFS_CMD_ARG:   rd_value = command_argument;
        OFS_RESP_FIFO: rd_value = '0;
        OFS_DATA_FIFO: rd_value = '0;
        default:       ok = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_control     <= '0;
      status_word       <= STATUS_AT_RESET;
      clock_rate        <= CLK_RATE_RESET;
      command_control   <= '0;
      response_timeout  <= RES_TO_RESET;
      read_timeout      <= READ_TO_RESET;
      block_length      <= '0;
      block_count       <= '0;
      interrupt_enables <= '0;
      command_index     <= '0;
      command_argument  <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        clock_control     <= clock_control_next;
        status_word       <= status_word_next;
        clock_rate        <= clock_rate_next;
        command_control   <= command_control_next;
        response_timeout  <= response_timeout_next;
        read_timeout      <= read_timeout_next;
        block_length      <= block_length_next;
        block_count       <= block_count_next;
        interrupt_enables <= interrupt_enables_next;
        command_index     <= command_index_next;
        command_argument  <= command_argument_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data  <= rd_value;
      irq        <= status_word_next[ST_END_CMD] && interrupt_enables_next[IE_END_CMD];
      bad_access <= !ok;
    end
  end

endmodule

// File: sv/sdhrs_checker.sv
// Port-level checker for the SD host register stub, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdhrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        bad_access
);

  // A stalled result must not be overwritten, so no transaction may enter.
  `CHK_SAME(a_no_overwrite, clk, rst, out_valid && !out_ready, !in_ready)

  // Every accepted transaction shows up as a result in the next cycle.
  `CHK_NEXT(a_one_cycle, clk, rst, in_valid && in_ready, out_valid)

  // Writes and refused accesses return zero data.
  `CHK_NEXT(a_write_zero, clk, rst, in_valid && in_ready && func, read_data == 32'h0)
  `CHK_SAME(a_bad_zero, clk, rst, out_valid && bad_access, read_data == 32'h0)

  // A stalled result holds its data.
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(read_data))

endmodule

bind sd_host_register_stub_top sdhrs_checker u_sdhrs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .func       (func),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_data  (read_data),
  .bad_access (bad_access)
);

// File: tb/sd_host_register_stub_top_tb.sv
// Self-checking testbench for the SD host register stub top level.
// Depends on sdhrs_pkg and sd_host_register_stub_top; predicts every reply with its own register mirror.
`timescale 1ns / 1ps

module sd_host_register_stub_top_tb;
  import sdhrs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 8;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct packed {
    word_t read_data;
    logic  irq;
    logic  bad_access;
  } reg_reply_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       func;
  ofs_t       offset;
  word_t      write_data;
  logic       out_valid;
  logic       out_ready;
  word_t      read_data;
  logic       irq;
  logic       bad_access;

  sd_host_register_stub_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .offset     (offset),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .irq        (irq),
    .bad_access (bad_access)
  );

  // Mirror of the register file.
  word_t m_clk_ctrl, m_status, m_clk_rate, m_cmd_ctrl, m_res_to, m_read_to;
  word_t m_blk_len, m_blk_cnt, m_int_en, m_cmd_idx, m_cmd_arg;

  reg_reply_t reg_replies[$];

  ofs_t mapped_ofs [14] = '{OFS_CLK_CTRL, OFS_STATUS, OFS_CLK_RATE, OFS_CMD_CTRL, OFS_RES_TO,
                            OFS_READ_TO, OFS_BLK_LEN, OFS_BLK_CNT, OFS_REVISION, OFS_INT_EN,
                            OFS_CMD_IDX, OFS_CMD_ARG, OFS_RESP_FIFO, OFS_DATA_FIFO};
  ofs_t plain_ofs [10] = '{OFS_CLK_CTRL, OFS_CLK_RATE, OFS_CMD_CTRL, OFS_RES_TO, OFS_READ_TO,
                           OFS_BLK_LEN, OFS_BLK_CNT, OFS_INT_EN, OFS_CMD_IDX, OFS_CMD_ARG};

  bit idle_on;
  // The stimulus side raises hold_requests; only the receiver advances hold_served.
  int hold_requests;
  int hold_served;
  int hold_left;
  int stall_left;
  int cycle_count;
  int mismatch_count;
  int accesses_sent;
  int replies_checked;
  int writes_sent;
  int refused_seen;
  int irq_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies still pending", cycle_count,
               reg_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void reset_mirror();
    m_clk_ctrl = '0;
    m_status   = STATUS_AT_RESET;
    m_clk_rate = CLK_RATE_RESET;
    m_cmd_ctrl = '0;
    m_res_to   = RES_TO_RESET;
    m_read_to  = READ_TO_RESET;
    m_blk_len  = '0;
    m_blk_cnt  = '0;
    m_int_en   = '0;
    m_cmd_idx  = '0;
    m_cmd_arg  = '0;
  endfunction

  // Applies one bus access to the mirror and returns the reply it must produce.
  function automatic reg_reply_t apply_bus_access(logic f, ofs_t o, word_t d);
    reg_reply_t r;
    r.read_data  = '0;
    r.bad_access = 1'b0;
    if (f == FUNC_WRITE) begin
      case (o)
        OFS_CLK_CTRL: begin
          m_clk_ctrl = d;
          // Stop wins when both bits are written together.
          if (d[CLK_START_BIT]) m_status[ST_CLK_RUNNING] = 1'b1;
          if (d[CLK_STOP_BIT])  m_status[ST_CLK_RUNNING] = 1'b0;
        end
        OFS_STATUS:    m_status = m_status & ~d;
        OFS_CLK_RATE:  m_clk_rate = d;
        OFS_CMD_CTRL: begin
          m_cmd_ctrl = d;
          m_status[ST_END_CMD] = 1'b1;
          m_status[ST_RESP_TIMEOUT] = 1'b1;
        end
        OFS_RES_TO:    m_res_to = d;
        OFS_READ_TO:   m_read_to = d;
        OFS_BLK_LEN:   m_blk_len = d;
        OFS_BLK_CNT:   m_blk_cnt = d;
        OFS_INT_EN:    m_int_en = d;
        OFS_CMD_IDX:   m_cmd_idx = d;
        OFS_CMD_ARG:   m_cmd_arg = d;
        OFS_DATA_FIFO: ;
        default:       r.bad_access = 1'b1;
      endcase
    end else begin
      case (o)
        OFS_CLK_CTRL:  r.read_data = m_clk_ctrl;
        OFS_STATUS:    r.read_data = m_status;
        OFS_CLK_RATE:  r.read_data = m_clk_rate;
        OFS_CMD_CTRL:  r.read_data = m_cmd_ctrl;
        OFS_RES_TO:    r.read_data = m_res_to;
        OFS_READ_TO:   r.read_data = m_read_to;
        OFS_BLK_LEN:   r.read_data = m_blk_len;
        OFS_BLK_CNT:   r.read_data = m_blk_cnt;
        OFS_REVISION:  r.read_data = REVISION_WORD;
        OFS_INT_EN:    r.read_data = m_int_en;
        OFS_CMD_IDX:   r.read_data = m_cmd_idx;
        OFS_CMD_ARG:   r.read_data = m_cmd_arg;
        OFS_RESP_FIFO: r.read_data = '0;
        OFS_DATA_FIFO: r.read_data = '0;
        default:       r.bad_access = 1'b1;
      endcase
    end
    r.irq = m_status[ST_END_CMD] & m_int_en[IE_END_CMD];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return word_t'(1) << $urandom_range(0, DataW - 1);
    return $urandom;
  endfunction

  function automatic ofs_t unmapped_ofs();
    ofs_t o;
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) o = 6'h30;
    else if (r == 1) o = 6'h3C;
    else begin
      o = ofs_t'($urandom_range(0, 63));
      if (o[1:0] == 2'b00) o[1:0] = 2'($urandom_range(1, 3));
    end
    return o;
  endfunction

  // Offers one transaction and records the reply it must produce once accepted.
  // in_valid is only lowered when a gap follows, so it never toggles within one step.
  task automatic send_access(logic f, ofs_t o, word_t d);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    offset     <= o;
    write_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reg_replies.push_back(apply_bus_access(f, o, d));
    accesses_sent++;
    if (f == FUNC_WRITE) writes_sent++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 25) stall_left = pick_gap() + 1;
    end
  end

  // Compares each reply with the oldest prediction.
  always @(posedge clk) begin : reply_check
    reg_reply_t want;
    if (!rst && out_valid && out_ready) begin
      replies_checked++;
      if (reg_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: reply with no transaction pending: data %h irq %b bad %b",
                   $realtime, read_data, irq, bad_access);
      end else begin
        want = reg_replies.pop_front();
        if (want.irq) irq_seen++;
        if (want.bad_access) refused_seen++;
        if (read_data !== want.read_data || irq !== want.irq ||
            bad_access !== want.bad_access) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: reply mismatch: data %h/%h irq %b/%b bad %b/%b (expected/actual)",
                     $realtime, want.read_data, read_data, want.irq, irq,
                     want.bad_access, bad_access);
        end
      end
    end
  end

  // Reset values, special bit behavior and refused offsets, one after another.
  task automatic test_directed();
    send_access(FUNC_READ,  OFS_STATUS,    '0);
    send_access(FUNC_READ,  OFS_REVISION,  '0);
    send_access(FUNC_READ,  OFS_CLK_RATE,  '0);
    send_access(FUNC_READ,  OFS_READ_TO,   '0);
    send_access(FUNC_WRITE, OFS_INT_EN,    '1);
    send_access(FUNC_WRITE, OFS_CMD_CTRL,  '0);
    send_access(FUNC_READ,  OFS_STATUS,    '0);
    send_access(FUNC_WRITE, OFS_CLK_CTRL,  32'h0000_0002);
    send_access(FUNC_READ,  OFS_STATUS,    '0);
    send_access(FUNC_WRITE, OFS_CLK_CTRL,  32'h0000_0003);
    send_access(FUNC_READ,  OFS_STATUS,    '0);
    send_access(FUNC_WRITE, OFS_STATUS,    '1);
    send_access(FUNC_READ,  OFS_STATUS,    '0);
    send_access(FUNC_WRITE, OFS_REVISION,  '1);
    send_access(FUNC_WRITE, OFS_RESP_FIFO, '1);
    send_access(FUNC_READ,  OFS_RESP_FIFO, '0);
    send_access(FUNC_WRITE, OFS_DATA_FIFO, 32'hA5A5_5A5A);
    send_access(FUNC_READ,  OFS_DATA_FIFO, '0);
    send_access(FUNC_READ,  6'h30,         '0);
    send_access(FUNC_READ,  6'h3F,         '0);
    send_access(FUNC_WRITE, 6'h3C,         '1);
    send_access(FUNC_WRITE, 6'h01,         '1);
    send_access(FUNC_WRITE, OFS_CLK_RATE,  '0);
    send_access(FUNC_READ,  OFS_CLK_RATE,  '0);
  endtask

  // Write a plain register, then read it back.
  task automatic test_register_readback(int rounds);
    ofs_t o;
    for (int i = 0; i < rounds; i++) begin
      o = plain_ofs[$urandom_range(0, 9)];
      send_access(FUNC_WRITE, o, rand_word());
      send_access(FUNC_READ, o, rand_word());
    end
  endtask

  // Command submits, clock start/stop, status clears and interrupt enable writes, watched through status reads.
  task automatic test_status_bits(int steps);
    word_t d;
    for (int i = 0; i < steps; i++) begin
      case ($urandom_range(0, 5))
        0: send_access(FUNC_WRITE, OFS_CMD_CTRL, rand_word());
        1: begin
          d = rand_word();
          d[1:0] = 2'($urandom_range(0, 3));
          send_access(FUNC_WRITE, OFS_CLK_CTRL, d);
        end
        2: send_access(FUNC_WRITE, OFS_STATUS, rand_word());
        3: send_access(FUNC_WRITE, OFS_INT_EN, rand_word());
        default: send_access(FUNC_READ, OFS_STATUS, rand_word());
      endcase
    end
  endtask

  task automatic test_refused_offsets(int steps);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_access(FUNC_WRITE, $urandom_range(0, 1) ? OFS_REVISION : OFS_RESP_FIFO,
                    rand_word());
      else
        send_access(logic'($urandom_range(0, 1)), unmapped_ofs(), rand_word());
    end
  endtask

  // The receiver holds off while accesses keep coming, so the input stalls.
  task automatic test_backpressure(int steps);
    bit saved_idle;
    saved_idle = idle_on;
    idle_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < steps; i++)
      send_access(logic'($urandom_range(0, 1)), mapped_ofs[$urandom_range(0, 13)], rand_word());
    idle_on = saved_idle;
  endtask

  // Bulk traffic over the whole window, with stretches free of any idling.
  task automatic test_random_mix(int steps);
    ofs_t o;
    for (int i = 0; i < steps; i++) begin
      if (i % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) o = mapped_ofs[$urandom_range(0, 13)];
      else o = ofs_t'($urandom_range(0, 63));
      send_access(logic'($urandom_range(0, 1)), o, rand_word());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int waited;
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = FUNC_READ;
    offset     = '0;
    write_data = '0;
    idle_on    = 1'b0;
    reset_mirror();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    idle_on = 1'b1;
    test_register_readback(150);
    test_status_bits(300);
    test_refused_offsets(150);
    test_backpressure(100);
    test_random_mix(900);
    in_valid <= 1'b0;

    waited = 0;
    while (reg_replies.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (reg_replies.size() > 0) begin
      mismatch_count++;
      $display("%0d predicted replies never arrived", reg_replies.size());
    end

    $display("Sent %0d transactions (%0d writes), checked %0d replies.",
             accesses_sent, writes_sent, replies_checked);
    $display("Refused accesses: %0d, replies with irq high: %0d, mismatches: %0d.",
             refused_seen, irq_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
